// ===== hw/rtl/fsmf_pkg.sv =====
package fsmf_pkg;

  localparam logic [1:0] REQ_PATTERN = 2'd0;
  localparam logic [1:0] REQ_TEXT    = 2'd1;
  localparam logic [1:0] REQ_END     = 2'd2;

  typedef struct packed {
    logic       shift;
    logic       step;
    logic       clear;
    logic       wr;
    logic [7:0] data;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/fsmf_cell.sv =====
module fsmf_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsmf_pkg::cell_ctl_t  ctl,
  input  logic                 sel,
  input  logic [7:0]           w_in,
  input  logic                 m_in,
  output logic [7:0]           w_out,
  output logic                 m_out,
  output logic                 m_nxt
);
  import fsmf_pkg::*;

  logic [7:0] w_r;
  logic [7:0] p_r;
  logic       m_r;

  assign m_nxt = m_in && (ctl.data == p_r);
  assign w_out = w_r;
  assign m_out = m_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      w_r <= w_in;
    end
    if (ctl.wr && sel) begin
      p_r <= ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= 1'b0;
    end else if (ctl.clear) begin
      m_r <= 1'b0;
    end else if (ctl.step) begin
      m_r <= m_nxt;
    end
  end

endmodule

// ===== hw/rtl/first_substring_match_finder.sv =====
// Channel   Direction  Beat contents
// cfg_*     in         pattern_length (7 bits), write-only, no handshake
// in_*      in         req_type, pattern_index, char_byte
// out_*     out        found, match_position, overflow (one beat per end of text)
//
// Every input beat waits while the window cells replay.
// A pattern write during a text stalls the input while the window cells
// rotate once and replay the held bytes through the prefix-match chain.
// Reset needs no clearing pass.
// An end-of-text beat also waits while an earlier result is held and not taken.
module first_substring_match_finder #(
  parameter int PATTERN_MAX = 64,
  parameter int TEXT_MAX    = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_pattern_index,
  input  logic [7:0]  in_char_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [15:0] out_match_position,
  output logic        out_overflow
);
  import fsmf_pkg::*;

  localparam int CW = $clog2(TEXT_MAX + 1);
  localparam int DW = (CW > 16) ? CW : 16;
  localparam int RW = $clog2(PATTERN_MAX + 1);
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  typedef enum logic {ST_RUN, ST_REPLAY} state_t;

  state_t          state_r;
  logic [6:0]      len_r;
  logic [CW-1:0]   text_count_r;
  logic [RW-1:0]   fill_r;
  logic [RW-1:0]   rp_cnt_r;
  logic            match_seen_r;
  logic [15:0]     first_pos_r;
  logic            ovf_r;
  logic            out_valid_r;
  logic            out_found_r;
  logic [15:0]     out_pos_r;
  logic            out_ovf_r;

  logic [8:0]      len_eff;
  logic [8:0]      len_m1;
  logic [IW-1:0]   len_idx;
  logic            len_zero;
  logic            is_pat;
  logic            is_text;
  logic            is_end;
  logic            slot_ok;
  logic            in_go;
  logic            pat_go;
  logic            text_go;
  logic            end_go;
  logic            replay;
  logic            replay_step;
  logic            count_full;
  logic [RW-1:0]   thr;
  logic [DW-1:0]   pos_nxt;
  cell_ctl_t       ctl;

  logic [7:0]              w_chain [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]  m_chain;
  logic [PATTERN_MAX-1:0]  m_nxt_all;

  assign len_eff  = ({2'b00, len_r} > 9'(PATTERN_MAX)) ? 9'(PATTERN_MAX) : {2'b00, len_r};
  assign len_zero = (len_eff == 9'd0);
  assign len_m1   = len_eff - 9'd1;
  assign len_idx  = len_m1[IW-1:0];

  assign is_pat  = (in_req_type == REQ_PATTERN);
  assign is_text = (in_req_type == REQ_TEXT);
  assign is_end  = (in_req_type == REQ_END);
  assign slot_ok = (int'(in_pattern_index) < PATTERN_MAX);

  assign replay     = (state_r == ST_REPLAY);
  assign in_ready   = !replay && (!is_end || !out_valid_r || out_ready);
  assign in_go      = in_valid && in_ready;
  assign count_full = (text_count_r == CW'(TEXT_MAX));
  assign pat_go     = in_go && is_pat && slot_ok;
  assign text_go    = in_go && is_text && !count_full;
  assign end_go     = in_go && is_end;

  assign thr         = RW'(PATTERN_MAX) - fill_r;
  assign replay_step = replay && (rp_cnt_r >= thr);
  assign pos_nxt     = DW'(text_count_r) + DW'(1) - DW'(len_eff);

  always_comb begin
    ctl.shift = text_go || replay;
    ctl.step  = text_go || replay_step;
    ctl.clear = end_go || pat_go;
    ctl.wr    = pat_go;
    ctl.data  = replay ? w_chain[PATTERN_MAX-1] : in_char_byte;
  end

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    fsmf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sel   (int'(in_pattern_index) == k),
      .w_in  ((k == 0) ? ctl.data : w_chain[(k == 0) ? 0 : k - 1]),
      .m_in  ((k == 0) ? 1'b1 : m_chain[(k == 0) ? 0 : k - 1]),
      .w_out (w_chain[k]),
      .m_out (m_chain[k]),
      .m_nxt (m_nxt_all[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RUN;
      len_r        <= '0;
      text_count_r <= '0;
      fill_r       <= '0;
      rp_cnt_r     <= '0;
      match_seen_r <= 1'b0;
      first_pos_r  <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      out_found_r  <= 1'b0;
      out_pos_r    <= '0;
      out_ovf_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        len_r <= cfg_wdata;
      end

      case (state_r)
        ST_RUN: begin
          if (pat_go && (fill_r != '0)) begin
            state_r  <= ST_REPLAY;
            rp_cnt_r <= '0;
          end
        end
        ST_REPLAY: begin
          rp_cnt_r <= rp_cnt_r + RW'(1);
          if (rp_cnt_r == RW'(PATTERN_MAX - 1)) begin
            state_r <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase

      if (text_go) begin
        text_count_r <= text_count_r + CW'(1);
        if (fill_r != RW'(PATTERN_MAX)) begin
          fill_r <= fill_r + RW'(1);
        end
        if (!match_seen_r && !len_zero && m_nxt_all[len_idx]) begin
          match_seen_r <= 1'b1;
          first_pos_r  <= pos_nxt[15:0];
        end
      end

      if (in_go && is_text && count_full) begin
        ovf_r <= 1'b1;
      end

      if (end_go) begin
        out_valid_r  <= 1'b1;
        out_found_r  <= len_zero || match_seen_r;
        out_pos_r    <= len_zero ? 16'd0 : first_pos_r;
        out_ovf_r    <= ovf_r;
        text_count_r <= '0;
        fill_r       <= '0;
        match_seen_r <= 1'b0;
        first_pos_r  <= '0;
        ovf_r        <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_position = out_pos_r;
  assign out_overflow       = out_ovf_r;

  assert property (@(posedge clk) disable iff (!rst_n) replay |-> !in_ready)
    else $error("input taken during replay");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_found_r |-> out_pos_r == 16'd0)
    else $error("position reported without a match");

  assert property (@(posedge clk) disable iff (!rst_n) text_count_r <= CW'(TEXT_MAX))
    else $error("text count beyond limit");

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= RW'(PATTERN_MAX))
    else $error("window fill beyond depth");

  assert property (@(posedge clk) disable iff (!rst_n) $rose(match_seen_r) |-> $past(text_go))
    else $error("match latched without a text beat");

endmodule

// ===== tb/first_substring_match_finder_checker.sv =====
module first_substring_match_finder_checker #(
  parameter int PATTERN_MAX = 64,
  parameter int TEXT_MAX    = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_pattern_index,
  input  logic [7:0]  in_char_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_found,
  input  logic [15:0] out_match_position,
  input  logic        out_overflow,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsmf_pkg::*;

  typedef struct packed {
    logic        found;
    logic [15:0] position;
    logic        overflow;
  } search_report_t;

  logic [7:0]                   pattern_mem [PATTERN_MAX];
  logic [7:0]                   recent_bytes [PATTERN_MAX];
  logic [$clog2(TEXT_MAX):0]    text_len;
  logic                         hit;
  logic [15:0]                  hit_pos;
  logic                         text_overflow;
  logic [6:0]                   pattern_len;
  search_report_t               expected_reports [$];

  function automatic logic window_equals(input int n);
    for (int k = 0; k < n; k++) begin
      if (recent_bytes[n - 1 - k] !== pattern_mem[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_text();
    for (int i = 0; i < PATTERN_MAX; i++) recent_bytes[i] = 8'h00;
    text_len      = '0;
    hit           = 1'b0;
    hit_pos       = '0;
    text_overflow = 1'b0;
  endtask

  task automatic search_step(input logic [1:0] req, input logic [5:0] idx, input logic [7:0] ch);
    int             n;
    search_report_t rep;
    n = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len);
    case (req)
      REQ_PATTERN: begin
        if (idx < PATTERN_MAX) pattern_mem[idx] = ch;
      end
      REQ_TEXT: begin
        if (text_len >= TEXT_MAX) begin
          text_overflow = 1'b1;
        end else begin
          for (int i = PATTERN_MAX - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i - 1];
          recent_bytes[0] = ch;
          text_len++;
          if (!hit && n > 0 && text_len >= n && window_equals(n)) begin
            hit     = 1'b1;
            hit_pos = 16'(text_len - n);
          end
        end
      end
      REQ_END: begin
        rep.found    = (n == 0) ? 1'b1 : hit;
        rep.position = (n == 0 || !hit) ? 16'd0 : hit_pos;
        rep.overflow = text_overflow;
        expected_reports.push_back(rep);
        clear_text();
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    search_report_t want;
    if (!rst_n) begin
      clear_text();
      pattern_len = '0;
      expected_reports.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (cfg_we) pattern_len = cfg_wdata;
      if (in_valid && in_ready) search_step(in_req_type, in_pattern_index, in_char_byte);
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: expected none, actual found %0d position %0d overflow %0d",
                   $time, out_found, out_match_position, out_overflow);
        end else begin
          want = expected_reports.pop_front();
          if (out_found !== want.found) begin
            errors++;
            $display("%0t: found: expected %0d actual %0d", $time, want.found, out_found);
          end
          if (out_match_position !== want.position) begin
            errors++;
            $display("%0t: match_position: expected %0d actual %0d",
                     $time, want.position, out_match_position);
          end
          if (out_overflow !== want.overflow) begin
            errors++;
            $display("%0t: overflow: expected %0d actual %0d", $time, want.overflow, out_overflow);
          end
        end
      end
      pending = expected_reports.size();
    end
  end

endmodule

// ===== tb/first_substring_match_finder_tb.sv =====
module first_substring_match_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fsmf_pkg::*;

  localparam int         PATTERN_MAX  = 64;
  localparam int         TEXT_MAX     = 65536;
  localparam logic [1:0] REQ_NONE     = 2'd3;
  localparam int         DRAIN_CYCLES = 80;
  localparam int         RANDOM_ITEMS = 1450;
  localparam int         QUIET_ITEMS  = 150;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        cfg_we           = 1'b0;
  logic [6:0]  cfg_wdata        = '0;
  logic        in_valid         = 1'b0;
  logic [1:0]  in_req_type      = REQ_PATTERN;
  logic [5:0]  in_pattern_index = '0;
  logic [7:0]  in_char_byte     = '0;
  logic        out_ready        = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_found;
  logic [15:0] out_match_position;
  logic        out_overflow;
  int          errors;
  int          pending;

  logic        quiet      = 1'b0;
  int          gap_pct    = 0;
  int          beats      = 0;
  int          stall_left = 0;
  int          run_left   = 0;
  logic [7:0]  pat_copy [PATTERN_MAX];
  logic [6:0]  cur_len    = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  first_substring_match_finder #(
    .PATTERN_MAX(PATTERN_MAX),
    .TEXT_MAX   (TEXT_MAX)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_pattern_index  (in_pattern_index),
    .in_char_byte      (in_char_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_position(out_match_position),
    .out_overflow      (out_overflow)
  );

  first_substring_match_finder_checker #(
    .PATTERN_MAX(PATTERN_MAX),
    .TEXT_MAX   (TEXT_MAX)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_pattern_index  (in_pattern_index),
    .in_char_byte      (in_char_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_position(out_match_position),
    .out_overflow      (out_overflow),
    .errors            (errors),
    .pending           (pending)
  );

  // stall the result side in random bursts
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_ready  <= 1'b0;
    end else begin
      run_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      out_ready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [1:0] req, input logic [5:0] idx, input logic [7:0] ch);
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_pattern_index <= idx;
    in_char_byte     <= ch;
    do @(posedge clk); while (!in_ready);
    if (req != REQ_NONE) beats++;
    if (req == REQ_PATTERN) pat_copy[idx] = ch;
  endtask

  task automatic send_text(input logic [7:0] ch);
    send_beat(REQ_TEXT, 6'($urandom), ch);
  endtask

  task automatic end_text();
    send_beat(REQ_END, 6'($urandom), 8'($urandom));
  endtask

  // hold the sender until every result is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [6:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_len   = v;
  endtask

  function automatic int eff_len();
    return (cur_len > PATTERN_MAX) ? PATTERN_MAX : int'(cur_len);
  endfunction

  function automatic logic [7:0] text_char(input int mode);
    return (mode == 0) ? 8'($urandom) : pat_copy[$urandom_range(0, 3)];
  endfunction

  initial begin : stimulus
    int         n;
    int         at;
    int         mode;
    int         plant;
    int         spoil;
    logic [7:0] b;
    repeat (11) @(posedge clk);
    rst_n   <= 1'b1;
    gap_pct = 30;

    for (int i = 0; i < PATTERN_MAX; i++) begin
      b = (i == 1) ? 8'hFF : (i == 0 || i == 2) ? 8'h00 : 8'($urandom);
      send_beat(REQ_PATTERN, 6'(i), b);
    end

    // empty pattern, with an empty and a short text
    end_text();
    send_text(8'h41);
    send_text(8'h42);
    end_text();

    // length above the store saturates
    set_length(7'd127);
    send_text(8'h7E);
    for (int i = 0; i < PATTERN_MAX; i++) send_text(pat_copy[i]);
    end_text();
    set_length(7'd64);
    for (int i = 0; i < PATTERN_MAX; i++) send_text(pat_copy[i] ^ ((i == 63) ? 8'h01 : 8'h00));
    end_text();

    set_length(7'd3);
    send_text(8'h00);
    send_beat(REQ_NONE, 6'h3F, 8'hFF);
    send_text(8'hFF);
    send_text(8'h00);
    send_text(8'hFF);
    send_text(8'h00);
    end_text();
    send_text(8'hFF);
    send_text(8'hFF);
    end_text();

    // rewrite a pattern slot mid-text
    send_text(8'h00);
    send_beat(REQ_PATTERN, 6'd1, 8'h55);
    send_text(8'h55);
    send_text(8'h00);
    end_text();

    // change the length mid-text
    send_text(8'h11);
    send_text(8'h00);
    set_length(7'd1);
    send_text(8'h22);
    send_text(8'h00);
    end_text();

    while (beats < RANDOM_ITEMS) begin
      if (beats >= RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet   = 1'b1;
        gap_pct = 0;
      end else begin
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      end
      if (!quiet && $urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 9))
          0: set_length(7'd0);
          1: set_length(7'd64);
          2: set_length(7'($urandom_range(65, 127)));
          3: set_length(7'($urandom));
          default: set_length(7'($urandom_range(1, 6)));
        endcase
      end
      n     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 20);
      at    = $urandom_range(0, n);
      mode  = $urandom_range(0, 2);
      plant = $urandom_range(0, 1);
      spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PATTERN_MAX - 1) : -1;
      for (int k = 0; k <= n; k++) begin
        if (plant != 0 && k == at) begin
          for (int j = 0; j < eff_len(); j++) begin
            send_text((j == spoil) ? 8'($urandom) : pat_copy[j]);
          end
        end
        if (k < n) begin
          send_text(text_char(mode));
          if ($urandom_range(0, 24) == 0) begin
            send_beat(REQ_PATTERN, 6'($urandom), text_char($urandom_range(0, 1)));
          end
          if ($urandom_range(0, 39) == 0) send_beat(REQ_NONE, 6'($urandom), 8'($urandom));
        end
      end
      if ($urandom_range(0, 19) != 0) end_text();
    end
    end_text();

    quiet = 1'b1;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
